// ----- src/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared definitions
// Field widths used by the channel interfaces, and the result record used by
// the conversion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int unsigned IN_W  = 16;
	localparam int unsigned OUT_W = 16;

	typedef struct packed {
		logic signed [OUT_W-1:0] quat_w;
		logic signed [OUT_W-1:0] quat_x;
		logic signed [OUT_W-1:0] quat_y;
		logic signed [OUT_W-1:0] quat_z;
		logic                    bad_input;
	} quat_res_t;

endpackage

// ----- src/rmq_ifs.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: channel interfaces
// Valid/ready channels for the input matrix and the resulting quaternion.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
	logic                              valid;
	logic                              ready;
	logic signed [rmq_pkg::IN_W-1:0] m00;
	logic signed [rmq_pkg::IN_W-1:0] m01;
	logic signed [rmq_pkg::IN_W-1:0] m02;
	logic signed [rmq_pkg::IN_W-1:0] m10;
	logic signed [rmq_pkg::IN_W-1:0] m11;
	logic signed [rmq_pkg::IN_W-1:0] m12;
	logic signed [rmq_pkg::IN_W-1:0] m20;
	logic signed [rmq_pkg::IN_W-1:0] m21;
	logic signed [rmq_pkg::IN_W-1:0] m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if;
	logic                               valid;
	logic                               ready;
	logic signed [rmq_pkg::OUT_W-1:0] quat_w;
	logic signed [rmq_pkg::OUT_W-1:0] quat_x;
	logic signed [rmq_pkg::OUT_W-1:0] quat_y;
	logic signed [rmq_pkg::OUT_W-1:0] quat_z;
	logic                               bad_input;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, bad_input,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, bad_input,
		output ready);
endinterface

// ----- src/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Pipelined conversion of a fixed-point 3x3 rotation matrix to a unit
// quaternion by Shoemake's method.
// ----------------------------------------------------------------------------
// The block accepts one matrix per clock cycle while mat.ready is high, and
// returns one quaternion per matrix, in order. The square-root pipeline
// resolves one root bit per stage for a root of RW bits, where
// RW = ceil((SW + FRAC_BITS) / 2) and SW = max(FRAC_BITS, 17) + 2; it is
// followed by the three parallel dividers, which resolve one quotient bit per
// stage. A two-entry output buffer lets the block keep accepting matrices while
// a result waits to be taken, until the skid entry fills and mat.ready falls.
module rotation_matrix_to_quaternion #(
	parameter int unsigned FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	rmq_mat_if.sink    mat,
	rmq_quat_if.source quat
);

	localparam int unsigned F     = FRAC_BITS;
	localparam int unsigned SW    = ((F > 17) ? F : 17) + 2;
	localparam int unsigned SSW   = SW + 1;
	localparam int unsigned VW    = SW + F;
	localparam int unsigned RW    = (VW + 1) / 2;
	localparam int unsigned RMW   = RW + 2;
	localparam int unsigned NSW   = 18;
	localparam int unsigned MAG_W = 17;
	localparam int unsigned QB    = 16;
	localparam int unsigned NW    = MAG_W + F + 1;
	localparam int unsigned DW    = RW + 1;
	localparam int unsigned CW    = (NW > DW + QB) ? NW : DW + QB;
	localparam int unsigned B_INT = (F < 15) ? (1 << F) : 32767;
	localparam logic [QB-1:0] B16 = QB'(B_INT);
	localparam logic signed [SSW-1:0] ONE_S = SSW'(1) << F;

	localparam logic [1:0] SLOT_W = 2'd0;
	localparam logic [1:0] SLOT_X = 2'd1;
	localparam logic [1:0] SLOT_Y = 2'd2;
	localparam logic [1:0] SLOT_Z = 2'd3;

	typedef struct packed {
		logic                         v;
		logic                         bad;
		logic [1:0]                   rslot;
		logic [2:0]                   neg;
		logic [2:0][MAG_W-1:0]        mag;
		logic [RMW-1:0]               rem;
		logic [RW-1:0]                root;
		logic [2*RW-1:0]              rad;
	} sq_t;

	typedef struct packed {
		logic                         v;
		logic                         bad;
		logic [1:0]                   rslot;
		logic [2:0]                   neg;
		logic [2:0]                   ovf;
		logic [RW-1:0]                root;
		logic [CW-1:0]                den;
		logic [2:0][CW-1:0]           rem;
		logic [2:0][QB-1:0]           q;
	} dv_t;

	logic               o_v_q, sk_v_q;
	logic en;
	assign en = !sk_v_q;
	assign mat.ready = en;

	// Front end: trace, branch, radicand and the three numerators.
	logic signed [SSW-1:0] a00, a11, a22, tr, s0, s1, s2, s_sel;
	logic signed [NSW-1:0] b01, b02, b10, b12, b20, b21;
	logic signed [NSW-1:0] dx, dy, dz, p01, p02, p12;
	logic signed [2:0][NSW-1:0] nl;
	logic [1:0] rsl;
	logic       pos;
	sq_t        f_d;

	assign a00 = SSW'(mat.m00);
	assign a11 = SSW'(mat.m11);
	assign a22 = SSW'(mat.m22);
	assign b01 = NSW'(mat.m01);
	assign b02 = NSW'(mat.m02);
	assign b10 = NSW'(mat.m10);
	assign b12 = NSW'(mat.m12);
	assign b20 = NSW'(mat.m20);
	assign b21 = NSW'(mat.m21);

	assign tr  = a00 + a11 + a22;
	assign pos = tr > 0;
	assign s0  = a00 - a11 - a22 + ONE_S;
	assign s1  = a11 - a22 - a00 + ONE_S;
	assign s2  = a22 - a00 - a11 + ONE_S;
	assign dx  = b21 - b12;
	assign dy  = b02 - b20;
	assign dz  = b10 - b01;
	assign p01 = b01 + b10;
	assign p02 = b02 + b20;
	assign p12 = b12 + b21;

	always_comb begin
		if (pos) begin
			rsl   = SLOT_W;
			s_sel = tr + ONE_S;
			nl    = {dz, dy, dx};
		end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
			rsl   = SLOT_Z;
			s_sel = s2;
			nl    = {p12, p02, dz};
		end else if (a11 > a00) begin
			rsl   = SLOT_Y;
			s_sel = s1;
			nl    = {p12, p01, dy};
		end else begin
			rsl   = SLOT_X;
			s_sel = s0;
			nl    = {p02, p01, dx};
		end
	end

	always_comb begin
		f_d       = '0;
		f_d.v     = mat.valid;
		f_d.bad   = !pos && (s_sel <= 0);
		f_d.rslot = rsl;
		for (int l = 0; l < 3; l++) begin
			f_d.neg[l] = nl[l][NSW-1];
			f_d.mag[l] = nl[l][NSW-1] ? MAG_W'(-nl[l]) : MAG_W'(nl[l]);
		end
		f_d.rad = ((2*RW)'(s_sel[SW-1:0])) << F;
	end

	sq_t sqrt_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_s[0] <= '0;
		end else if (en) begin
			sqrt_s[0] <= f_d;
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 1; k <= RW; k++) begin : g_sqrt
		logic [RMW-1:0] rem2, trial;
		sq_t            nx;

		always_comb begin
			nx    = sqrt_s[k-1];
			rem2  = {sqrt_s[k-1].rem[RMW-3:0], sqrt_s[k-1].rad[2*RW-1 -: 2]};
			trial = {sqrt_s[k-1].root, 2'b01};
			nx.rad = sqrt_s[k-1].rad << 2;
			if (rem2 >= trial) begin
				nx.rem  = rem2 - trial;
				nx.root = {sqrt_s[k-1].root[RW-2:0], 1'b1};
			end else begin
				nx.rem  = rem2;
				nx.root = {sqrt_s[k-1].root[RW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_s[k] <= '0;
			end else if (en) begin
				sqrt_s[k] <= nx;
			end
		end
	end

	// Divider set-up: rounded dividend, divisor 2r and quotient overflow.
	dv_t div_s [0:QB];
	dv_t d0_d;

	always_comb begin
		d0_d       = '0;
		d0_d.v     = sqrt_s[RW].v;
		d0_d.bad   = sqrt_s[RW].bad;
		d0_d.rslot = sqrt_s[RW].rslot;
		d0_d.neg   = sqrt_s[RW].neg;
		d0_d.root  = sqrt_s[RW].root;
		d0_d.den   = CW'({sqrt_s[RW].root, 1'b0});
		for (int l = 0; l < 3; l++) begin
			d0_d.rem[l] = (CW'(sqrt_s[RW].mag[l]) << F) + CW'(sqrt_s[RW].root);
			d0_d.ovf[l] = d0_d.rem[l] >= (d0_d.den << QB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (en) begin
			div_s[0] <= d0_d;
		end
	end

	// Restoring division, one quotient bit per stage in each of three lanes.
	for (genvar b = 1; b <= QB; b++) begin : g_div
		logic [CW-1:0] t;
		dv_t           nx;

		assign t = div_s[b-1].den << (QB - b);

		always_comb begin
			nx = div_s[b-1];
			for (int l = 0; l < 3; l++) begin
				if (div_s[b-1].rem[l] >= t) begin
					nx.rem[l]       = div_s[b-1].rem[l] - t;
					nx.q[l][QB - b] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[b] <= '0;
			end else if (en) begin
				div_s[b] <= nx;
			end
		end
	end

	// Saturation and placement of the components.
	logic [RW-1:0]              rh;
	logic signed [QB-1:0]       rv;
	logic signed [2:0][QB-1:0]  lv;
	logic [QB-1:0]              qm;
	rmq_pkg::quat_res_t         res_d;

	always_comb begin
		rh = div_s[QB].root >> 1;
		rv = (rh > RW'(B_INT)) ? B16 : QB'(rh);
		for (int l = 0; l < 3; l++) begin
			qm    = (div_s[QB].ovf[l] || (div_s[QB].q[l] > B16)) ? B16 : div_s[QB].q[l];
			lv[l] = div_s[QB].neg[l] ? -qm : qm;
		end
		res_d           = '0;
		res_d.bad_input = div_s[QB].bad;
		if (!div_s[QB].bad) begin
			case (div_s[QB].rslot)
				SLOT_W: res_d = '{quat_w: rv, quat_x: lv[0], quat_y: lv[1],
						quat_z: lv[2], bad_input: 1'b0};
				SLOT_X: res_d = '{quat_w: lv[0], quat_x: rv, quat_y: lv[1],
						quat_z: lv[2], bad_input: 1'b0};
				SLOT_Y: res_d = '{quat_w: lv[0], quat_x: lv[1], quat_y: rv,
						quat_z: lv[2], bad_input: 1'b0};
				default: res_d = '{quat_w: lv[0], quat_x: lv[1], quat_y: lv[2],
						quat_z: rv, bad_input: 1'b0};
			endcase
		end
	end

	// Output register with a skid entry behind it.
	rmq_pkg::quat_res_t o_q, sk_q;
	logic               fresh;

	assign fresh = en && div_s[QB].v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!o_v_q || quat.ready) begin
			if (sk_v_q) begin
				o_v_q  <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				o_v_q <= fresh;
			end
		end else if (fresh) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || quat.ready) begin
			o_q <= sk_v_q ? sk_q : res_d;
		end else if (fresh) begin
			sk_q <= res_d;
		end
	end

	assign quat.valid     = o_v_q;
	assign quat.quat_w    = o_q.quat_w;
	assign quat.quat_x    = o_q.quat_x;
	assign quat.quat_y    = o_q.quat_y;
	assign quat.quat_z    = o_q.quat_z;
	assign quat.bad_input = o_q.bad_input;

endmodule
